// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the matrix multiplier.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that, when seen, must be followed by another in the next cycle.
`define SMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/smm_pkg.sv
// ---------------------------------------------------------------------------
// Matrix multiplier package
// Fixed widths, reset values and the tag passed to the multiply-accumulate.
// ---------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

  // Width and reset value of the size register.
  localparam int unsigned DimBits = 3;
  localparam logic [DimBits-1:0] DimReset = 3'd3;

  // Tag travelling with each pair of operands read from the stores.
  typedef struct packed {
    logic issue;
    logic first;
    logic last;
  } smm_tag_t;

endpackage

`default_nettype wire

// File: sv/smm_in_if.sv
// ---------------------------------------------------------------------------
// Load channel
// Carries one element of each matrix with its position per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface smm_in_if #(
  parameter int IDX_BITS  = 2,
  parameter int ELEM_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [IDX_BITS-1:0]         row_index;
  logic [IDX_BITS-1:0]         col_index;
  logic signed [ELEM_BITS-1:0] a_value;
  logic signed [ELEM_BITS-1:0] b_value;
  logic                        load_done;

  modport source (
    output valid, row_index, col_index, a_value, b_value, load_done,
    input  ready
  );
  modport sink (
    input  valid, row_index, col_index, a_value, b_value, load_done,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/smm_out_if.sv
// ---------------------------------------------------------------------------
// Product channel
// Carries one element of the product matrix with its position per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface smm_out_if #(
  parameter int IDX_BITS  = 2,
  parameter int PROD_BITS = 34
);
  logic                        valid;
  logic                        ready;
  logic [IDX_BITS-1:0]         out_row;
  logic [IDX_BITS-1:0]         out_col;
  logic signed [PROD_BITS-1:0] product_value;
  logic                        is_last;

  modport source (
    output valid, out_row, out_col, product_value, is_last,
    input  ready
  );
  modport sink (
    input  valid, out_row, out_col, product_value, is_last,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/smm_store.sv
// ---------------------------------------------------------------------------
// Matrix stores
// Two synchronous memories holding A and B, one write port shared by both
// and one registered read port each.
// ---------------------------------------------------------------------------
`default_nettype none

module smm_store #(
  parameter int MAX_DIM   = 4,
  parameter int ELEM_BITS = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       wr_en_i,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0]       wr_addr_i,
  input  wire logic [ELEM_BITS-1:0]                       wr_a_i,
  input  wire logic [ELEM_BITS-1:0]                       wr_b_i,
  input  wire logic                                       rd_en_i,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0]       rd_addr_a_i,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0]       rd_addr_b_i,
  output logic      [ELEM_BITS-1:0]                       rd_a_o,
  output logic      [ELEM_BITS-1:0]                       rd_b_o
);

  localparam int Depth    = MAX_DIM * MAX_DIM;
  localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1;

  logic [ELEM_BITS-1:0] mem_a [Depth];
  logic [ELEM_BITS-1:0] mem_b [Depth];

  // Element writes from the load channel.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_a[wr_addr_i[AddrBits-1:0]] <= wr_a_i;
      mem_b[wr_addr_i[AddrBits-1:0]] <= wr_b_i;
    end
  end

  // Operand reads, data registered.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_o <= mem_a[rd_addr_a_i[AddrBits-1:0]];
      rd_b_o <= mem_b[rd_addr_b_i[AddrBits-1:0]];
    end
  end

endmodule

`default_nettype wire

// File: sv/smm_mac.sv
// ---------------------------------------------------------------------------
// Multiply-accumulate
// Registered multiply followed by a registered accumulator; flags the cycle
// after the last term of a dot product has been added.
// ---------------------------------------------------------------------------
`default_nettype none

module smm_mac #(
  parameter int ELEM_BITS = 16,
  parameter int PROD_BITS = 34
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire smm_pkg::smm_tag_t           tag_i,
  input  wire logic signed [ELEM_BITS-1:0] a_i,
  input  wire logic signed [ELEM_BITS-1:0] b_i,
  output logic                             done_o,
  output logic signed [PROD_BITS-1:0]      acc_o
);

  smm_pkg::smm_tag_t             tag1_q, tag2_q;
  logic                          done_q;
  logic signed [2*ELEM_BITS-1:0] prod_q;
  logic signed [PROD_BITS-1:0]   acc_q, acc_d, term;

  // Tag pipeline, aligned with the store read and the multiply.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      done_q <= 1'b0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      done_q <= tag2_q.issue && tag2_q.last;
    end
  end

  // Multiply stage: operands arrive from the store read registers.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // Accumulate stage: the first term of a dot product restarts the sum.
  assign term  = PROD_BITS'(prod_q);
  assign acc_d = tag2_q.first ? term : acc_q + term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (tag2_q.issue) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

// File: sv/square_matrix_multiply.sv
// ---------------------------------------------------------------------------
// Square matrix multiplier
// Loads A and B element by element over in_i, then computes C = A x B and
// returns every element of C in row-major order over out_o.
// Each in_i transfer writes one element of A and B at (row, col); it is
// accepted whenever no product run is in progress. The transfer with
// load_done set is stored too and then starts the run.
// The size in use comes from the dim register (0 counts as 1, values above
// MAX_DIM as MAX_DIM); write it only while the block is idle.
// Each product element is worked out with one memory read per cycle per
// store through the single multiply-accumulate, followed by the read,
// multiply and accumulate stages and a hand-over state.
// The last product sits in the output register while new loads are taken.
// If out_o stalls, the held element stays and the next element does not
// start until it is transferred.
// Reset empties the output register, returns to idle and sets dim to 3; the
// stores are not cleared and must be loaded before use.
// ---------------------------------------------------------------------------
`default_nettype none

module square_matrix_multiply #(
  parameter int MAX_DIM   = 4,
  parameter int ELEM_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         dim_we_i,
  input  wire logic [smm_pkg::DimBits-1:0]  dim_wdata_i,
  smm_in_if.sink                            in_i,
  smm_out_if.source                         out_o
);

  localparam int IdxBits   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CntBits   = $clog2(MAX_DIM + 1);
  localparam int APortBits = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int ProdBits  = 2 * ELEM_BITS + IdxBits;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_ISSUE = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  logic [smm_pkg::DimBits-1:0]  dim_q;
  logic [IdxBits-1:0]           i_q, i_d, j_q, j_d, k_q, k_d;
  logic                         out_valid_q, out_valid_d;
  logic [IdxBits-1:0]           out_row_q, out_row_d, out_col_q, out_col_d;
  logic signed [ProdBits-1:0]   out_prod_q, out_prod_d;
  logic                         out_last_q, out_last_d;
  logic [CntBits-1:0]           n, n_last;
  logic                         in_accept, out_take;
  logic                         row_end, col_end;
  logic                         wr_en;
  logic [APortBits-1:0]         wr_addr, rd_addr_a, rd_addr_b;
  logic [ELEM_BITS-1:0]         rd_a, rd_b;
  smm_pkg::smm_tag_t            tag;
  logic                         mac_done;
  logic signed [ProdBits-1:0]   mac_acc;

  // Size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= smm_pkg::DimReset;
    end else if (dim_we_i) begin
      dim_q <= dim_wdata_i;
    end
  end

  // Size in use, clamped to the built range.
  always_comb begin
    if (dim_q == '0) begin
      n = CntBits'(1);
    end else if (int'(dim_q) > MAX_DIM) begin
      n = CntBits'(MAX_DIM);
    end else begin
      n = CntBits'(dim_q);
    end
    n_last = CntBits'(n - CntBits'(1));
  end

  // Handshakes.
  assign in_accept = in_i.valid && in_i.ready;
  assign out_take  = out_valid_q && out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // Load writes: positions outside the store are dropped.
  assign wr_en   = in_accept && (int'(in_i.row_index) < MAX_DIM)
                   && (int'(in_i.col_index) < MAX_DIM);
  assign wr_addr = APortBits'(APortBits'(in_i.row_index) * APortBits'(MAX_DIM)
                   + APortBits'(in_i.col_index));

  // Operand addresses: A[i][k] and B[k][j].
  assign rd_addr_a = APortBits'(APortBits'(i_q) * APortBits'(MAX_DIM) + APortBits'(k_q));
  assign rd_addr_b = APortBits'(APortBits'(k_q) * APortBits'(MAX_DIM) + APortBits'(j_q));

  assign row_end = (CntBits'(i_q) == n_last);
  assign col_end = (CntBits'(j_q) == n_last);

  // Sequencer: steps through (i, j, k) and hands each dot product over.
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    tag         = '0;
    out_valid_d = out_valid_q && !out_take;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_prod_d  = out_prod_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && in_i.load_done) begin
          state_d = ST_START;
          i_d     = '0;
          j_d     = '0;
        end
      end
      ST_START: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_ISSUE;
          k_d     = '0;
        end
      end
      ST_ISSUE: begin
        tag.issue = 1'b1;
        tag.first = (k_q == '0);
        tag.last  = (CntBits'(k_q) == n_last);
        k_d       = k_q + 1'b1;
        if (tag.last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          out_valid_d = 1'b1;
          out_row_d   = i_q;
          out_col_d   = j_q;
          out_prod_d  = mac_acc;
          out_last_d  = row_end && col_end;
          if (row_end && col_end) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_START;
            if (col_end) begin
              j_d = '0;
              i_d = i_q + 1'b1;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_prod_q <= out_prod_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_row       = out_row_q;
  assign out_o.out_col       = out_col_q;
  assign out_o.product_value = out_prod_q;
  assign out_o.is_last       = out_last_q;

  // Matrix stores.
  smm_store #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_a_i      (in_i.a_value),
    .wr_b_i      (in_i.b_value),
    .rd_en_i     (tag.issue),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_a_o      (rd_a),
    .rd_b_o      (rd_b)
  );

  // Multiply-accumulate.
  smm_mac #(
    .ELEM_BITS (ELEM_BITS),
    .PROD_BITS (ProdBits)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag),
    .a_i    ($signed(rd_a)),
    .b_i    ($signed(rd_b)),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  // Checks.
`include "assert_macros.svh"

  `SMM_ASSERT(a_no_overwrite, !(mac_done && out_valid_q), "product would overwrite a held result")
  `SMM_ASSERT(a_done_in_wait, !mac_done || state_q == ST_WAIT, "dot product finished out of sequence")
  `SMM_ASSERT_NEXT(a_run_starts, in_accept && in_i.load_done, state_q == ST_START && !in_i.ready, "run did not start after the final load")

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Matrix multiplier testbench
// Loads element pairs into square_matrix_multiply over the load channel and
// checks every product element against a matrix product worked out here.
// Runs through several matrix sizes, partial reloads and stray loads, with
// the sender idling and the receiver stalling at random in several phases.
// ---------------------------------------------------------------------------

module tb;

  localparam int MaxDim = 4;
  localparam int ElemBits = 16;
  localparam int ProdBits = 34;
  localparam int LoadsPerPhase = 15;
  localparam int NumPhases = 10;
  localparam int SettleCycles = 24;
  localparam int unsigned LimitNs = 5_000_000;
  localparam logic signed [ElemBits-1:0] MinElem = 16'sh8000;
  localparam logic signed [ElemBits-1:0] MaxElem = 16'sh7fff;
  localparam int unsigned SizePlan [NumPhases] = '{1, 0, 7, 2, 5, 3, 6, 4, 2, 1};

  typedef enum int {
    IdleNone,
    IdleSource,
    IdleSink,
    IdleBoth
  } idle_mode_e;

  typedef struct packed {
    logic [1:0]                 row;
    logic [1:0]                 col;
    logic signed [ElemBits-1:0] a;
    logic signed [ElemBits-1:0] b;
    logic                       done;
  } load_item_t;

  typedef struct packed {
    logic [1:0]                 row;
    logic [1:0]                 col;
    logic signed [ProdBits-1:0] value;
    logic                       last;
  } product_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         dim_we_i = 1'b0;
  logic [smm_pkg::DimBits-1:0]  dim_wdata_i = '0;
  logic                         load_valid = 1'b0;
  load_item_t                   load_item = '0;
  logic                         prod_ready = 1'b0;

  // Copy of the block's state as the matrix product sees it.
  logic signed [ElemBits-1:0]   a_store [MaxDim][MaxDim];
  logic signed [ElemBits-1:0]   b_store [MaxDim][MaxDim];
  logic [smm_pkg::DimBits-1:0]  dim_shadow = smm_pkg::DimReset;

  product_t                     expected_products [$];
  load_item_t                   pending_loads [$];
  logic [MaxDim*MaxDim-1:0]     loaded_mask = '0;
  idle_mode_e                   idle_mode = IdleNone;
  int                           loads_queued = 0;
  int                           loads_sent = 0;
  int                           products_checked = 0;
  int                           runs_seen = 0;
  int                           errors = 0;

  smm_in_if #(.IDX_BITS(2), .ELEM_BITS(ElemBits)) load_ch ();
  smm_out_if #(.IDX_BITS(2), .PROD_BITS(ProdBits)) prod_ch ();

  assign load_ch.valid     = load_valid;
  assign load_ch.row_index = load_item.row;
  assign load_ch.col_index = load_item.col;
  assign load_ch.a_value   = load_item.a;
  assign load_ch.b_value   = load_item.b;
  assign load_ch.load_done = load_item.done;
  assign prod_ch.ready     = prod_ready;

  square_matrix_multiply #(
    .MAX_DIM  (MaxDim),
    .ELEM_BITS(ElemBits)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dim_we_i   (dim_we_i),
    .dim_wdata_i(dim_wdata_i),
    .in_i       (load_ch),
    .out_o      (prod_ch)
  );

  always #5 clk_i = ~clk_i;

  // Size register value to matrix size: zero counts as one, large values clamp.
  function automatic int unsigned active_size(input logic [smm_pkg::DimBits-1:0] d);
    if (d == 0) return 1;
    if (d > MaxDim) return MaxDim;
    return int'(d);
  endfunction

  // Stores one element pair and, on the final load, predicts the whole product.
  function automatic void store_and_multiply(input load_item_t item);
    int unsigned n;
    longint dot;
    product_t p;
    if (item.row < MaxDim && item.col < MaxDim) begin
      a_store[item.row][item.col] = item.a;
      b_store[item.row][item.col] = item.b;
    end
    if (!item.done) return;
    n = active_size(dim_shadow);
    runs_seen++;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        dot = 0;
        for (int k = 0; k < n; k++)
          dot += longint'(a_store[i][k]) * longint'(b_store[k][j]);
        p.row   = 2'(i);
        p.col   = 2'(j);
        p.value = dot[ProdBits-1:0];
        p.last  = (i == n - 1) && (j == n - 1);
        expected_products.push_back(p);
      end
    end
  endfunction

  // Compares one product transfer with the oldest prediction.
  function automatic void check_product();
    product_t want;
    if (expected_products.size() == 0) begin
      $error("product at row %0d col %0d arrived with nothing expected",
             prod_ch.out_row, prod_ch.out_col);
      errors++;
      return;
    end
    want = expected_products.pop_front();
    products_checked++;
    if (prod_ch.out_row !== want.row) begin
      $error("out_row: expected %0d, got %0d", want.row, prod_ch.out_row);
      errors++;
    end
    if (prod_ch.out_col !== want.col) begin
      $error("out_col: expected %0d, got %0d", want.col, prod_ch.out_col);
      errors++;
    end
    if (prod_ch.product_value !== want.value) begin
      $error("product_value: expected %0d, got %0d", want.value, prod_ch.product_value);
      errors++;
    end
    if (prod_ch.is_last !== want.last) begin
      $error("is_last: expected %0d, got %0d", want.last, prod_ch.is_last);
      errors++;
    end
  endfunction

  function automatic bit source_idles();
    case (idle_mode)
      IdleSource: return $urandom_range(99) < 71;
      IdleBoth:   return $urandom_range(99) < 9;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic bit sink_stalls();
    case (idle_mode)
      IdleSink: return $urandom_range(99) < 71;
      IdleBoth: return $urandom_range(99) < 9;
      default:  return 1'b0;
    endcase
  endfunction

  // Load driver: records each transfer and offers the next pending item.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      load_valid <= 1'b0;
      load_item  <= '0;
    end else begin
      if (load_valid && load_ch.ready) begin
        store_and_multiply(load_item);
        loads_sent++;
      end
      if (!load_valid || load_ch.ready) begin
        if (pending_loads.size() != 0 && !source_idles()) begin
          load_item  <= pending_loads.pop_front();
          load_valid <= 1'b1;
        end else begin
          load_valid <= 1'b0;
        end
      end
    end
  end

  // Product monitor: checks each transfer and stalls at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      prod_ready <= 1'b0;
    end else begin
      if (prod_ch.valid && prod_ready) check_product();
      prod_ready <= !sink_stalls();
    end
  end

  // Half extremes and small values, the other half spread over the whole range.
  function automatic logic signed [ElemBits-1:0] pick_element();
    case ($urandom_range(7))
      0:       return MinElem;
      1:       return MaxElem;
      2:       return -16'sd1;
      3:       return 16'sd0;
      default: return ElemBits'($urandom);
    endcase
  endfunction

  function automatic bit size_loaded(input int unsigned n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (!loaded_mask[i*MaxDim+j]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic queue_load(input int unsigned row, input int unsigned col,
                            input logic signed [ElemBits-1:0] a,
                            input logic signed [ElemBits-1:0] b, input bit done);
    load_item_t item;
    item.row  = 2'(row);
    item.col  = 2'(col);
    item.a    = a;
    item.b    = b;
    item.done = done;
    loaded_mask[row*MaxDim+col] = 1'b1;
    pending_loads.push_back(item);
    loads_queued++;
  endtask

  // One multiply run: mostly a full reload in shuffled order, sometimes a
  // partial reload, occasionally preceded by stray loads anywhere in the store.
  task automatic queue_run(input int unsigned n);
    int unsigned order [$];
    int unsigned pick;
    int unsigned tmp;
    int unsigned count;
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3))
        queue_load($urandom_range(MaxDim - 1), $urandom_range(MaxDim - 1),
                   pick_element(), pick_element(), 1'b0);
    if (!size_loaded(n) || $urandom_range(9) < 6) begin
      for (int p = 0; p < n * n; p++) order.push_back(p);
      for (int p = n * n - 1; p > 0; p--) begin
        pick = $urandom_range(p);
        tmp = order[p];
        order[p] = order[pick];
        order[pick] = tmp;
      end
    end else begin
      count = $urandom_range(1, n * n);
      repeat (count) order.push_back($urandom_range(n * n - 1));
    end
    foreach (order[p])
      queue_load(order[p] / n, order[p] % n, pick_element(), pick_element(),
                 p == order.size() - 1);
  endtask

  // Waits until every load has been transferred and every product checked.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_loads.size() != 0 || load_valid || expected_products.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_dim(input int unsigned value);
    @(posedge clk_i);
    dim_we_i    <= 1'b1;
    dim_wdata_i <= smm_pkg::DimBits'(value);
    @(posedge clk_i);
    dim_we_i    <= 1'b0;
    dim_shadow   = smm_pkg::DimBits'(value);
    @(negedge clk_i);
  endtask

  // Stimulus: directed runs at the extremes, then random phases.
  initial begin
    int target;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset size: a load outside the size in use, then all-minimum operands.
    queue_load(3, 3, MaxElem, MaxElem, 1'b0);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        queue_load(i, j, MinElem, MinElem, i == 2 && j == 2);
    wait_idle();

    // Full size: the largest sum, then the smallest in row 0, then a
    // single-element reload that starts a run by itself.
    write_dim(MaxDim);
    for (int i = 0; i < MaxDim; i++)
      queue_load(i, MaxDim - 1, MinElem, MinElem, 1'b0);
    for (int j = 0; j < MaxDim - 1; j++)
      queue_load(MaxDim - 1, j, MinElem, MinElem, j == MaxDim - 2);
    for (int j = 0; j < MaxDim; j++)
      queue_load(0, j, MaxElem, MinElem, j == MaxDim - 1);
    queue_load(1, 1, 16'sd0, 16'sd0, 1'b1);
    wait_idle();

    for (int phase = 0; phase < NumPhases; phase++) begin
      write_dim(SizePlan[phase]);
      idle_mode = idle_mode_e'(phase % 4);
      target = loads_queued + LoadsPerPhase;
      while (loads_queued < target) queue_run(active_size(dim_shadow));
      wait_idle();
    end

    $display("Covered %0d load transfers and %0d product transfers in %0d runs,",
             loads_sent, products_checked, runs_seen);
    $display("with size register values 0 to 7 and all four idling patterns.");
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Hard stop in case the block stops answering.
  initial begin
    #(LimitNs);
    $display("tb NOT OK");
    $finish;
  end

endmodule
